### design/dlsq_pkg.sv
package dlsq_pkg;

    // Default sizing of the queue.
    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int DELAY_BITS_DEF  = 16;

    // Fixed widths of the channel fields.
    localparam int OPCODE_W    = 1;
    localparam int HANDLE_W    = 8;
    localparam int DELAY_IN_W  = 16;
    localparam int KIND_W      = 2;
    localparam int OCCUPANCY_W = 6;

    // Input opcodes.
    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_EXPIRED  = 2'd0,
        KIND_ACCEPTED = 2'd1,
        KIND_REJECTED = 2'd2
    } kind_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_PLACE,
        ST_TICK,
        ST_EMIT
    } state_t;

endpackage

### design/dlsq_req_if.sv
interface dlsq_req_if;

    logic                              valid;
    logic                              ready;
    logic [dlsq_pkg::OPCODE_W-1:0]     opcode;
    logic [dlsq_pkg::HANDLE_W-1:0]     task_handle;
    logic [dlsq_pkg::DELAY_IN_W-1:0]   delay_ticks;

    modport source (output valid, output opcode, output task_handle, output delay_ticks,
                    input ready);
    modport sink   (input valid, input opcode, input task_handle, input delay_ticks,
                    output ready);

endinterface

### design/dlsq_rsp_if.sv
interface dlsq_rsp_if;

    logic                              valid;
    logic                              ready;
    logic [dlsq_pkg::KIND_W-1:0]       result_kind;
    logic [dlsq_pkg::HANDLE_W-1:0]     woken_handle;
    logic                              last_of_run;
    logic [dlsq_pkg::OCCUPANCY_W-1:0]  occupancy;

    modport source (output valid, output result_kind, output woken_handle,
                    output last_of_run, output occupancy, input ready);
    modport sink   (input valid, input result_kind, input woken_handle,
                    input last_of_run, input occupancy, output ready);

endinterface

### design/delta_list_sleep_queue.sv
// Sorted sleep queue kept as a delta list in a circular buffer of one RAM. An insert
// walks the list from the head one entry per cycle, then moves the entries behind
// the insertion point back by one, one entry per cycle, and writes the new entry.
// The walk and the move together visit at most one entry more than the queue holds.
// A rejected insert on a full queue goes straight to its result without the RAM. A
// tick first decrements the head delta, then pops the expired entries one by one; on
// an empty queue it gives no result. A result that waits for the output register to
// be taken holds the sequencer. The steps are serialised by the single read port and
// single write port of the entry RAM and the one shared subtractor.
// One word is worked on at a time; the next input word is taken once the previous
// one is finished, while its last result may still wait in the output register.
// There is no clearing pass after reset: only entries below the fill count are read.
module delta_list_sleep_queue #(
    parameter int QUEUE_DEPTH = dlsq_pkg::QUEUE_DEPTH_DEF,
    parameter int DELAY_BITS  = dlsq_pkg::DELAY_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dlsq_req_if.sink   req,
    dlsq_rsp_if.source rsp
);

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int HW     = dlsq_pkg::HANDLE_W;
    localparam int WORD_W = HW + DELAY_BITS;
    localparam logic [IDX_W:0]     DEPTH_IDX = (IDX_W + 1)'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0]   DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [31:0]        DELAY_MAX = 32'((64'd1 << DELAY_BITS) - 64'd1);

    // Control and payload registers.
    dlsq_pkg::state_t           state_reg, state_next;
    dlsq_pkg::kind_t            kind_reg, kind_next;
    logic [IDX_W-1:0]           head_reg, head_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [IDX_W-1:0]           pos_reg, pos_next;
    logic [IDX_W-1:0]           src_reg, src_next;
    logic [DELAY_BITS-1:0]      rem_reg, rem_next;
    logic [HW-1:0]              hold_reg, hold_next;
    logic                       pend_reg, pend_next;
    logic                       first_reg, first_next;

    // Output register.
    logic                              out_valid_reg, out_valid_next;
    dlsq_pkg::kind_t                   out_kind_reg, out_kind_next;
    logic [HW-1:0]                     out_handle_reg, out_handle_next;
    logic                              out_last_reg, out_last_next;
    logic [dlsq_pkg::OCCUPANCY_W-1:0]  out_occ_reg, out_occ_next;

    // RAM and subtractor connections.
    logic                  ram_we, ram_re;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [WORD_W-1:0]     ram_wdata, ram_rdata;
    logic [DELAY_BITS-1:0] rd_delta;
    logic [HW-1:0]         rd_handle;
    logic [DELAY_BITS-1:0] alu_a, alu_b, alu_diff;
    logic                  alu_ge;

    // Per-cycle helpers.
    logic                  accept;
    logic                  emit, emit_ok, emit_last;
    dlsq_pkg::kind_t       emit_kind;
    logic [HW-1:0]         emit_handle;
    logic [31:0]           delay_wide;
    logic [31:0]           delay_sat;
    logic [DELAY_BITS-1:0] eff_delta;

    // Logical position in the list to RAM address, wrapping around the buffer.
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                              input logic [IDX_W-1:0] idx);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, idx};
        if (sum >= DEPTH_IDX)
        begin
            sum = sum - DEPTH_IDX;
        end
        return sum[IDX_W-1:0];
    endfunction

    dlsq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dlsq_alu #(
        .WIDTH (DELAY_BITS)
    ) u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .ge   (alu_ge)
    );

    assign rd_delta  = ram_rdata[DELAY_BITS-1:0];
    assign rd_handle = ram_rdata[WORD_W-1 -: HW];

    // Handshakes.
    assign req.ready = (state_reg == dlsq_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign emit_ok   = !out_valid_reg || rsp.ready;

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_kind  = out_kind_reg;
    assign rsp.woken_handle = out_handle_reg;
    assign rsp.last_of_run  = out_last_reg;
    assign rsp.occupancy    = out_occ_reg;

    // Requested delay clamped to the largest delta the list can hold.
    assign delay_wide = 32'(req.delay_ticks);
    assign delay_sat  = (delay_wide > DELAY_MAX) ? DELAY_MAX : delay_wide;

    // Sequencer: next state, RAM accesses and result emission.
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        head_next  = head_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        src_next   = src_reg;
        rem_next   = rem_reg;
        hold_next  = hold_reg;
        pend_next  = pend_reg;
        first_next = first_reg;

        ram_we    = 1'b0;
        ram_waddr = head_reg;
        ram_wdata = {rd_handle, rd_delta};
        ram_re    = 1'b0;
        ram_raddr = head_reg;
        alu_a     = rd_delta;
        alu_b     = DELAY_BITS'(1);
        eff_delta = rd_delta;

        emit        = 1'b0;
        emit_kind   = dlsq_pkg::KIND_EXPIRED;
        emit_handle = hold_reg;
        emit_last   = 1'b1;

        unique case (state_reg)
            dlsq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.opcode == dlsq_pkg::OP_INSERT)
                    begin
                        hold_next = req.task_handle;
                        rem_next  = delay_sat[DELAY_BITS-1:0];
                        pos_next  = '0;
                        if (count_reg == DEPTH_CNT)
                        begin
                            kind_next  = dlsq_pkg::KIND_REJECTED;
                            state_next = dlsq_pkg::ST_EMIT;
                        end
                        else
                        begin
                            kind_next = dlsq_pkg::KIND_ACCEPTED;
                            if (count_reg == '0)
                            begin
                                state_next = dlsq_pkg::ST_PLACE;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                state_next = dlsq_pkg::ST_SCAN;
                            end
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        ram_re     = 1'b1;
                        first_next = 1'b1;
                        pend_next  = 1'b0;
                        state_next = dlsq_pkg::ST_TICK;
                    end
                end
            end

            // Walk past every entry whose running total does not exceed the delay.
            dlsq_pkg::ST_SCAN:
            begin
                alu_a = rem_reg;
                alu_b = rd_delta;
                if (alu_ge)
                begin
                    rem_next = alu_diff;
                    pos_next = pos_reg + IDX_W'(1);
                    if (CNT_W'(pos_reg) + CNT_W'(1) == count_reg)
                    begin
                        state_next = dlsq_pkg::ST_PLACE;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = phys(head_reg, pos_reg + IDX_W'(1));
                        state_next = dlsq_pkg::ST_SCAN;
                    end
                end
                else
                begin
                    src_next   = IDX_W'(count_reg - CNT_W'(1));
                    ram_re     = 1'b1;
                    ram_raddr  = phys(head_reg, IDX_W'(count_reg - CNT_W'(1)));
                    state_next = dlsq_pkg::ST_SHIFT;
                end
            end

            // Move entries back by one from the tail down to the insertion point;
            // the entry that ends up behind the new one loses the new delta.
            dlsq_pkg::ST_SHIFT:
            begin
                alu_a     = rd_delta;
                alu_b     = rem_reg;
                ram_we    = 1'b1;
                ram_waddr = phys(head_reg, src_reg + IDX_W'(1));
                if (src_reg == pos_reg)
                begin
                    ram_wdata  = {rd_handle, alu_diff};
                    state_next = dlsq_pkg::ST_PLACE;
                end
                else
                begin
                    ram_wdata  = {rd_handle, rd_delta};
                    src_next   = src_reg - IDX_W'(1);
                    ram_re     = 1'b1;
                    ram_raddr  = phys(head_reg, src_reg - IDX_W'(1));
                end
            end

            dlsq_pkg::ST_PLACE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = phys(head_reg, pos_reg);
                ram_wdata  = {hold_reg, rem_reg};
                count_next = count_reg + CNT_W'(1);
                state_next = dlsq_pkg::ST_EMIT;
            end

            // Decrement the head once, then pop leading zero deltas. Each popped
            // handle is held back until the next head shows whether it is the last.
            dlsq_pkg::ST_TICK:
            begin
                if (first_reg)
                begin
                    eff_delta = alu_ge ? alu_diff : '0;
                end
                if (eff_delta == '0)
                begin
                    if (!pend_reg || emit_ok)
                    begin
                        emit       = pend_reg;
                        emit_last  = 1'b0;
                        hold_next  = rd_handle;
                        pend_next  = 1'b1;
                        first_next = 1'b0;
                        head_next  = phys(head_reg, IDX_W'(1));
                        count_next = count_reg - CNT_W'(1);
                        if (count_reg == CNT_W'(1))
                        begin
                            kind_next  = dlsq_pkg::KIND_EXPIRED;
                            state_next = dlsq_pkg::ST_EMIT;
                        end
                        else
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = phys(head_reg, IDX_W'(1));
                        end
                    end
                end
                else if (first_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = head_reg;
                    ram_wdata  = {rd_handle, eff_delta};
                    state_next = dlsq_pkg::ST_IDLE;
                end
                else if (emit_ok)
                begin
                    emit       = 1'b1;
                    state_next = dlsq_pkg::ST_IDLE;
                end
            end

            dlsq_pkg::ST_EMIT:
            begin
                if (emit_ok)
                begin
                    emit       = 1'b1;
                    emit_kind  = kind_reg;
                    state_next = dlsq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dlsq_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register loads on emission and empties when taken.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_handle_next = out_handle_reg;
        out_last_next   = out_last_reg;
        out_occ_next    = out_occ_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = emit_kind;
            out_handle_next = emit_handle;
            out_last_next   = emit_last;
            out_occ_next    = dlsq_pkg::OCCUPANCY_W'(count_reg);
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dlsq_pkg::ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        pos_reg        <= pos_next;
        src_reg        <= src_next;
        rem_reg        <= rem_next;
        hold_reg       <= hold_next;
        out_kind_reg   <= out_kind_next;
        out_handle_reg <= out_handle_next;
        out_last_reg   <= out_last_next;
        out_occ_reg    <= out_occ_next;
    end

endmodule

### design/dlsq_ram.sv
module dlsq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port; read data holds while idle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/dlsq_alu.sv
module dlsq_alu #(
    parameter int WIDTH = 16
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH-1:0] diff,
    output logic             ge
);

    logic [WIDTH:0] full;

    // Single subtractor; the borrow tells whether a is at least b.
    assign full = {1'b0, a} - {1'b0, b};
    assign diff = full[WIDTH-1:0];
    assign ge   = ~full[WIDTH];

endmodule

### tb/tb_delta_list_sleep_queue.sv
module tb_delta_list_sleep_queue;

    timeunit 1ns;
    timeprecision 1ps;

    import dlsq_pkg::*;

    localparam int DEPTH        = QUEUE_DEPTH_DEF;
    localparam int SETTLE       = 2 * DEPTH + 8;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int REPORT_LIMIT = 10;

    // One answer word as it leaves the block.
    typedef struct packed {
        kind_t                  kind;
        logic [HANDLE_W-1:0]    handle;
        logic                   last;
        logic [OCCUPANCY_W-1:0] occ;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n;

    dlsq_req_if req_bus ();
    dlsq_rsp_if rsp_bus ();

    delta_list_sleep_queue uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Shadow copy of the delta list and the answers it still owes.
    logic [DELAY_BITS_DEF-1:0] list_delta  [DEPTH];
    logic [HANDLE_W-1:0]       list_handle [DEPTH];
    int                        list_count;
    answer_t                   answers_due [$];

    int idle_pct;
    int stall_pct;
    int errors;
    int cycles;

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver back-pressure, changed on the falling edge.
    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Apply one accepted word to the shadow list and queue the answers it causes.
    function automatic void advance_list(op_t op, logic [HANDLE_W-1:0] handle,
                                         logic [DELAY_IN_W-1:0] delay);
        int                        pos;
        logic [DELAY_BITS_DEF-1:0] rem;
        logic [HANDLE_W-1:0]       woken;
        answer_t                   ans;
        int                        n;
        pos = 0;
        n   = 0;
        if (op == OP_INSERT)
        begin
            if (list_count >= DEPTH)
            begin
                ans = '{KIND_REJECTED, handle, 1'b1, list_count[OCCUPANCY_W-1:0]};
                answers_due.push_back(ans);
                return;
            end
            // Walk past every entry whose total wait is not above the delay.
            rem = delay;
            while (pos < list_count && rem >= list_delta[pos])
            begin
                rem = rem - list_delta[pos];
                pos++;
            end
            for (int i = list_count; i > pos; i--)
            begin
                list_delta[i]  = list_delta[i-1];
                list_handle[i] = list_handle[i-1];
            end
            if (pos < list_count)
                list_delta[pos+1] = list_delta[pos+1] - rem;
            list_delta[pos]  = rem;
            list_handle[pos] = handle;
            list_count++;
            ans = '{KIND_ACCEPTED, handle, 1'b1, list_count[OCCUPANCY_W-1:0]};
            answers_due.push_back(ans);
            return;
        end

        // Timer tick: the head delta saturates at zero, then leading zeros expire.
        if (list_count == 0)
            return;
        if (list_delta[0] > 0)
            list_delta[0] = list_delta[0] - 1'b1;
        while (list_count > 0 && list_delta[0] == 0)
        begin
            woken = list_handle[0];
            for (int i = 0; i < list_count - 1; i++)
            begin
                list_delta[i]  = list_delta[i+1];
                list_handle[i] = list_handle[i+1];
            end
            list_count--;
            ans = '{KIND_EXPIRED, woken, 1'b0, list_count[OCCUPANCY_W-1:0]};
            answers_due.push_back(ans);
            n++;
        end
        if (n > 0)
        begin
            ans = answers_due.pop_back();
            ans.last = 1'b1;
            answers_due.push_back(ans);
        end
    endfunction

    // Compare every answer word taken from the block with the oldest one owed.
    always @(posedge clk)
    begin : check_answers
        answer_t got;
        answer_t want;
        if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            got = '{kind_t'(rsp_bus.result_kind), rsp_bus.woken_handle,
                    rsp_bus.last_of_run, rsp_bus.occupancy};
            if (answers_due.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: unexpected word kind=%0d handle=%0d last=%0d occ=%0d",
                             $realtime, got.kind, got.handle, got.last, got.occ);
            end
            else
            begin
                want = answers_due.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                    begin
                        $write("%0t: mismatch expected kind=%0d handle=%0d last=%0d occ=%0d",
                               $realtime, want.kind, want.handle, want.last, want.occ);
                        $display(", got kind=%0d handle=%0d last=%0d occ=%0d",
                                 got.kind, got.handle, got.last, got.occ);
                    end
                end
            end
        end
    end

    // Send one word; returns at the falling edge after it was accepted, valid still high.
    task automatic issue_word(op_t op, logic [HANDLE_W-1:0] handle,
                              logic [DELAY_IN_W-1:0] delay);
        while ($urandom_range(99) < idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.opcode      <= op;
        req_bus.task_handle <= handle;
        req_bus.delay_ticks <= delay;
        @(posedge clk);
        while (req_bus.ready !== 1'b1)
            @(posedge clk);
        advance_list(op, handle, delay);
        @(negedge clk);
    endtask

    task automatic sleep_task(logic [HANDLE_W-1:0] handle, logic [DELAY_IN_W-1:0] delay);
        issue_word(OP_INSERT, handle, delay);
    endtask

    // A tick carries random values in the fields it does not use.
    task automatic timer_tick();
        issue_word(OP_TICK, HANDLE_W'($urandom), DELAY_IN_W'($urandom));
    endtask

    // Hold off the sender until every owed answer has come, then let the block settle.
    task automatic await_answers();
        req_bus.valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    function automatic logic [DELAY_IN_W-1:0] pick_delay();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return DELAY_IN_W'($urandom_range(7));
        else if (r < 98)
            return DELAY_IN_W'($urandom_range(31));
        return DELAY_IN_W'($urandom_range(255));
    endfunction

    // Ticks on an empty queue give nothing back.
    task automatic test_empty_tick();
        timer_tick();
        timer_tick();
        await_answers();
    endtask

    // Ordering: zero delay, equal waits, middle insert, append at the tail.
    task automatic test_ordering();
        sleep_task(8'h00, 16'd0);
        sleep_task(8'hFF, 16'd1);
        sleep_task(8'h11, 16'd3);
        sleep_task(8'h22, 16'd3);
        sleep_task(8'h33, 16'd2);
        sleep_task(8'h44, 16'd10);
        sleep_task(8'h55, 16'd0);
        timer_tick();
        timer_tick();
        timer_tick();
        timer_tick();
        sleep_task(8'h66, 16'd6);
        repeat (8) timer_tick();
        await_answers();
    endtask

    // Fill the queue with equal waits, hit the full case, then expire all at once.
    task automatic test_full_queue();
        while (list_count > 0)
            timer_tick();
        for (int i = 0; i < DEPTH; i++)
            sleep_task(HANDLE_W'($urandom), 16'd1);
        sleep_task(8'hA5, 16'd0);
        sleep_task(8'h5A, 16'd7);
        timer_tick();
        await_answers();
    endtask

    // Random traffic in bursts that fill, drain or mix.
    task automatic test_random_phase(int items, int idle, int stall);
        int sent;
        int burst_len;
        int insert_pct;
        int mode;
        idle_pct  = idle;
        stall_pct = stall;
        sent      = 0;
        while (sent < items)
        begin
            mode       = $urandom_range(2);
            burst_len  = $urandom_range(30, 8);
            insert_pct = (mode == 0) ? 75 : ((mode == 1) ? 25 : 50);
            for (int b = 0; b < burst_len && sent < items; b++)
            begin
                if ($urandom_range(99) < insert_pct)
                    sleep_task(HANDLE_W'($urandom_range(255)), pick_delay());
                else
                    timer_tick();
                sent++;
            end
        end
        await_answers();
    endtask

    // Long delays that reach the upper delay bits; these entries stay behind.
    task automatic test_wide_delay();
        sleep_task(8'h7E, 16'hFFFF);
        sleep_task(8'h81, 16'h5555);
        sleep_task(8'h18, 16'hAAAA);
        sleep_task(8'hE7, 16'h8000);
        sleep_task(HANDLE_W'($urandom), DELAY_IN_W'($urandom));
        repeat (4) timer_tick();
        await_answers();
    endtask

    // Main sequence.
    initial
    begin
        errors              = 0;
        cycles              = 0;
        idle_pct            = 0;
        stall_pct           = 0;
        list_count          = 0;
        rst_n               = 1'b0;
        req_bus.valid       = 1'b0;
        req_bus.opcode      = OP_INSERT;
        req_bus.task_handle = '0;
        req_bus.delay_ticks = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_tick();
        test_ordering();
        test_full_queue();
        test_random_phase(76, 0, 0);
        test_random_phase(76, 73, 0);
        test_random_phase(76, 0, 73);
        test_random_phase(76, 36, 36);
        test_wide_delay();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
design/dlsq_pkg.sv
design/dlsq_req_if.sv
design/dlsq_rsp_if.sv
design/dlsq_ram.sv
design/dlsq_alu.sv
design/delta_list_sleep_queue.sv
tb/tb_delta_list_sleep_queue.sv
